FILE: rtl/sgfe_pkg.sv
package sgfe_pkg;

	// Default bank size and group limit.
	localparam int NUM_ELEMENTS_DEF = 16;
	localparam int MAX_GROUPS_DEF = 4;

	// The four group bound registers are fixed by the register map.
	localparam int NUM_GROUP_REGS = 4;

	// Steps of the shared multiply and divide unit, one bit per cycle.
	localparam int ALU_STEPS = 32;
	localparam int ALU_CW = $clog2(ALU_STEPS);

	// Request kinds.
	typedef enum logic [1:0] {
		K_LOAD    = 2'd0,
		K_PREDICT = 2'd1,
		K_UPDATE  = 2'd2,
		K_NONE    = 2'd3
	} kind_t;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		CFG_GROUP0      = 3'd0,
		CFG_GROUP1      = 3'd1,
		CFG_GROUP2      = 3'd2,
		CFG_GROUP3      = 3'd3,
		CFG_GROUP_COUNT = 3'd4
	} cfg_idx_t;

	// Operation of the shared arithmetic unit.
	typedef enum logic {
		ALU_MUL = 1'b0,
		ALU_DIV = 1'b1
	} alu_op_t;

	// Command from the sequencer to the arithmetic unit.
	typedef struct packed {
		logic    start;
		alu_op_t op;
	} alu_cmd_t;

	// One input request.
	typedef struct packed {
		logic [1:0]         kind;
		logic [3:0]         element_index;
		logic signed [31:0] in_mean;
		logic [31:0]        in_variance;
		logic               measurement_missing;
		logic               last_element;
	} in_t;

	// One result.
	typedef struct packed {
		logic [7:0]         result_index;
		logic signed [31:0] out_mean;
		logic [31:0]        out_variance;
		logic               is_fused;
		logic               applied;
		logic               math_error;
		logic               last_result;
	} out_t;

endpackage

FILE: rtl/sgfe_alu.sv
// Shared bit-serial multiplier and restoring divider.
// Multiply: 32 x 32 bit unsigned, 64-bit product.
// Divide: 64-bit dividend by 33-bit divisor; the quotient must fit 32 bits.
module sgfe_alu (
	input  logic              clk,
	input  logic              arst_n,
	input  sgfe_pkg::alu_cmd_t cmd,
	input  logic [63:0]       src_a,
	input  logic [32:0]       src_b,
	output logic              done,
	output logic [63:0]       result
);
	import sgfe_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [ALU_CW-1:0] cnt_q;
	alu_op_t           op_q;
	logic [32:0]       hi_q;
	logic [31:0]       lo_q;
	logic [32:0]       opnd_q;

	logic [33:0] msum;
	logic [33:0] trial;
	logic [34:0] diff;
	logic [32:0] hi_nxt;
	logic [31:0] lo_nxt;

	// One add or subtract step per cycle.
	always_comb begin
		msum = {1'b0, hi_q} + (lo_q[0] ? {1'b0, opnd_q} : 34'd0);
		trial = {hi_q, lo_q[31]};
		diff = {1'b0, trial} - {2'b00, opnd_q};
		unique case (op_q)
			ALU_MUL: begin
				hi_nxt = msum[33:1];
				lo_nxt = {msum[0], lo_q[31:1]};
			end
			ALU_DIV: begin
				hi_nxt = diff[34] ? trial[32:0] : diff[32:0];
				lo_nxt = {lo_q[30:0], ~diff[34]};
			end
			default: begin
				hi_nxt = hi_q;
				lo_nxt = lo_q;
			end
		endcase
	end

	// Step counter and completion pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
			op_q <= ALU_MUL;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
				op_q <= cmd.op;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == ALU_CW'(ALU_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Operand and partial result registers.
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			lo_q <= src_a[31:0];
			opnd_q <= src_b;
			hi_q <= (cmd.op == ALU_DIV) ? {1'b0, src_a[63:32]} : 33'd0;
		end else if (busy_q) begin
			hi_q <= hi_nxt;
			lo_q <= lo_nxt;
		end
	end

	assign done = done_q;
	assign result = (op_q == ALU_MUL) ? {hi_q[31:0], lo_q} : {32'd0, lo_q};

endmodule

FILE: rtl/scalar_gaussian_fusion_estimator.sv
// Bank of scalar Gaussians (Q16.16 mean and variance) with load, predict and
// measurement update requests, followed by optional inverse-variance fusion of
// up to four configured groups after the last update of a vector. One request
// is handled at a time; in_stall stays high until its last result has been
// placed in the output register. Every product-of-Gaussians step runs two
// multiplies and two divides through one shared bit-serial unit. A fusion group
// scans each of its elements, runs one such step for each non-zero-variance
// element after the first, then reports. The state store needs no clearing
// pass: per-entry valid bits make unwritten entries read as zero.
module scalar_gaussian_fusion_estimator #(
	parameter int NUM_ELEMENTS = sgfe_pkg::NUM_ELEMENTS_DEF,
	parameter int MAX_GROUPS = sgfe_pkg::MAX_GROUPS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  sgfe_pkg::in_t  in_data,
	output logic           out_valid,
	input  logic           out_stall,
	output sgfe_pkg::out_t out_data,
	input  logic           cfg_we,
	input  logic [2:0]     cfg_index,
	input  logic [15:0]    cfg_data
);
	import sgfe_pkg::*;

	localparam int IW = (NUM_ELEMENTS > 1) ? $clog2(NUM_ELEMENTS) : 1;

	typedef enum logic [10:0] {
		S_IDLE   = 11'b000_0000_0001,
		S_DECIDE = 11'b000_0000_0010,
		S_PREP   = 11'b000_0000_0100,
		S_MUL1   = 11'b000_0000_1000,
		S_DIV1   = 11'b000_0001_0000,
		S_MUL2   = 11'b000_0010_0000,
		S_DIV2   = 11'b000_0100_0000,
		S_EMIT   = 11'b000_1000_0000,
		S_GSTART = 11'b001_0000_0000,
		S_GREAD  = 11'b010_0000_0000,
		S_GCHECK = 11'b100_0000_0000
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [15:0] grp_cfg_q [NUM_GROUP_REGS];
	logic [2:0]  gcnt_q;
	logic [2:0]  cnt_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_GROUP_REGS; k++) begin
				grp_cfg_q[k] <= '0;
			end
			gcnt_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_GROUP0:      grp_cfg_q[0] <= cfg_data;
				CFG_GROUP1:      grp_cfg_q[1] <= cfg_data;
				CFG_GROUP2:      grp_cfg_q[2] <= cfg_data;
				CFG_GROUP3:      grp_cfg_q[3] <= cfg_data;
				CFG_GROUP_COUNT: gcnt_q <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	assign cnt_eff = (gcnt_q > 3'(MAX_GROUPS)) ? 3'(MAX_GROUPS) : gcnt_q;

	// State store with per-entry valid bits.
	logic [31:0]   mem_m [NUM_ELEMENTS];
	logic [31:0]   mem_v [NUM_ELEMENTS];
	logic          vld_q [NUM_ELEMENTS];
	logic [IW-1:0] rd_addr;
	logic [31:0]   rd_m_q, rd_v_q;
	logic          rd_vld_q;
	logic [31:0]   em, ev;
	logic          mem_we;
	logic [IW-1:0] wr_addr_q;

	// Request fields and working registers.
	kind_t       kind_q;
	logic [3:0]  idx_q;
	logic [31:0] im_q, iv_q;
	logic        miss_q, last_q;
	logic [31:0] cm0_q, ca_q, cm1_q, cb_q, mo_q;
	logic [32:0] sum_q;
	logic        neg_q, err_q, fusing_q, wr_en_q;
	out_t        res_q, out_q;
	logic        out_valid_q;
	logic        grp_q, any_q;
	logic [2:0]  g_q;
	logic [8:0]  i_q;
	logic [7:0]  end_q;
	logic [31:0] am_q, av_q;

	logic in_acc, out_free;
	assign in_acc = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != S_IDLE);

	assign rd_addr = (state_q == S_IDLE) ? IW'(in_data.element_index) : IW'(i_q);
	assign mem_we = (state_q == S_EMIT) && out_free && wr_en_q;

	always_ff @(posedge clk) begin
		rd_m_q <= mem_m[rd_addr];
		rd_v_q <= mem_v[rd_addr];
		if (mem_we) begin
			mem_m[wr_addr_q] <= res_q.out_mean;
			mem_v[wr_addr_q] <= res_q.out_variance;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_ELEMENTS; k++) begin
				vld_q[k] <= 1'b0;
			end
			rd_vld_q <= 1'b0;
		end else begin
			rd_vld_q <= vld_q[rd_addr];
			if (mem_we) begin
				vld_q[wr_addr_q] <= 1'b1;
			end
		end
	end

	assign em = rd_vld_q ? rd_m_q : 32'd0;
	assign ev = rd_vld_q ? rd_v_q : 32'd0;

	// Shared arithmetic unit.
	alu_cmd_t    alu_cmd;
	logic [63:0] alu_a;
	logic [32:0] alu_b;
	logic        alu_done;
	logic [63:0] alu_res;

	sgfe_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (alu_cmd),
		.src_a  (alu_a),
		.src_b  (alu_b),
		.done   (alu_done),
		.result (alu_res)
	);

	// Difference of means for the product step.
	logic signed [32:0] dmean;
	logic [32:0]        dabs;
	assign dmean = {cm1_q[31], cm1_q} - {cm0_q[31], cm0_q};
	assign dabs = dmean[32] ? (33'd0 - dmean) : dmean;

	// Command issue to the arithmetic unit.
	always_comb begin
		alu_cmd = '{start: 1'b0, op: ALU_MUL};
		alu_a = '0;
		alu_b = '0;
		unique case (state_q)
			S_PREP: begin
				alu_cmd = '{start: 1'b1, op: ALU_MUL};
				alu_a = {32'd0, dabs[31:0]};
				alu_b = {1'b0, ca_q};
			end
			S_MUL1, S_MUL2: begin
				alu_cmd = '{start: alu_done, op: ALU_DIV};
				alu_a = alu_res;
				alu_b = sum_q;
			end
			S_DIV1: begin
				alu_cmd = '{start: alu_done, op: ALU_MUL};
				alu_a = {32'd0, ca_q};
				alu_b = {1'b0, cb_q};
			end
			default: ;
		endcase
	end

	// Arithmetic for predict, update and fusion decisions.
	logic [32:0] p_m, p_v, miss_t;
	logic        p_m_ovf;
	logic [31:0] upd_b, upd_m1;
	logic [32:0] upd_sum;
	logic        in_bank;
	logic        fuse_next, more_grp;
	logic [15:0] bounds;
	logic [8:0]  end_ext;

	always_comb begin
		p_m = {em[31], em} + {im_q[31], im_q};
		p_m_ovf = p_m[32] != p_m[31];
		p_v = {1'b0, ev} + {1'b0, iv_q};
		miss_t = {1'b0, ev} + {3'b000, ev[31:2]};
		upd_b = miss_q ? (miss_t[32] ? 32'hFFFF_FFFF : miss_t[31:0]) : iv_q;
		upd_m1 = miss_q ? em : im_q;
		upd_sum = {1'b0, ev} + {1'b0, upd_b};
		in_bank = {5'd0, idx_q} < 9'(NUM_ELEMENTS);
		fuse_next = !grp_q && (kind_q == K_UPDATE) && last_q && (cnt_eff != 3'd0);
		more_grp = grp_q && ((g_q + 3'd1) < cnt_eff);
		bounds = grp_cfg_q[g_q[1:0]];
		end_ext = {1'b0, end_q};
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
			out_q <= '0;
			res_q <= '0;
			kind_q <= K_NONE;
			idx_q <= '0;
			im_q <= '0;
			iv_q <= '0;
			miss_q <= 1'b0;
			last_q <= 1'b0;
			cm0_q <= '0;
			ca_q <= '0;
			cm1_q <= '0;
			cb_q <= '0;
			mo_q <= '0;
			sum_q <= '0;
			neg_q <= 1'b0;
			err_q <= 1'b0;
			fusing_q <= 1'b0;
			wr_en_q <= 1'b0;
			wr_addr_q <= '0;
			grp_q <= 1'b0;
			any_q <= 1'b0;
			g_q <= '0;
			i_q <= '0;
			end_q <= '0;
			am_q <= '0;
			av_q <= '0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						kind_q <= kind_t'(in_data.kind);
						idx_q <= in_data.element_index;
						im_q <= in_data.in_mean;
						iv_q <= in_data.in_variance;
						miss_q <= in_data.measurement_missing;
						last_q <= in_data.last_element;
						grp_q <= 1'b0;
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					wr_addr_q <= IW'(idx_q);
					res_q <= '0;
					res_q.result_index <= {4'd0, idx_q};
					wr_en_q <= 1'b0;
					state_q <= S_EMIT;
					if (kind_q == K_NONE) begin
						state_q <= S_IDLE;
					end else if (!in_bank) begin
						wr_en_q <= 1'b0;
					end else begin
						unique case (kind_q)
							K_LOAD: begin
								res_q.out_mean <= im_q;
								res_q.out_variance <= iv_q;
								res_q.applied <= 1'b1;
								wr_en_q <= 1'b1;
							end
							K_PREDICT: begin
								res_q.out_mean <= p_m_ovf ?
									(p_m[32] ? 32'h8000_0000 : 32'h7FFF_FFFF) : p_m[31:0];
								res_q.out_variance <= p_v[32] ? 32'hFFFF_FFFF : p_v[31:0];
								res_q.math_error <= p_m_ovf || p_v[32];
								res_q.applied <= 1'b1;
								wr_en_q <= 1'b1;
							end
							default: begin
								err_q <= miss_q && miss_t[32];
								if (upd_sum == 33'd0) begin
									res_q.out_mean <= em;
									res_q.out_variance <= ev;
									res_q.math_error <= 1'b1;
								end else begin
									cm0_q <= em;
									ca_q <= ev;
									cm1_q <= upd_m1;
									cb_q <= upd_b;
									fusing_q <= 1'b0;
									state_q <= S_PREP;
								end
							end
						endcase
					end
				end
				S_PREP: begin
					sum_q <= {1'b0, ca_q} + {1'b0, cb_q};
					neg_q <= dmean[32];
					state_q <= S_MUL1;
				end
				S_MUL1: begin
					if (alu_done) begin
						state_q <= S_DIV1;
					end
				end
				S_DIV1: begin
					if (alu_done) begin
						mo_q <= neg_q ? (cm0_q - alu_res[31:0]) : (cm0_q + alu_res[31:0]);
						state_q <= S_MUL2;
					end
				end
				S_MUL2: begin
					if (alu_done) begin
						state_q <= S_DIV2;
					end
				end
				S_DIV2: begin
					if (alu_done) begin
						if (fusing_q) begin
							am_q <= mo_q;
							av_q <= alu_res[31:0];
							i_q <= i_q + 9'd1;
							state_q <= S_GREAD;
						end else begin
							res_q.out_mean <= mo_q;
							res_q.out_variance <= alu_res[31:0];
							res_q.applied <= 1'b1;
							res_q.math_error <= err_q;
							wr_en_q <= 1'b1;
							state_q <= S_EMIT;
						end
					end
				end
				S_EMIT: begin
					if (out_free) begin
						out_q <= res_q;
						out_q.last_result <= !(fuse_next || more_grp);
						out_valid_q <= 1'b1;
						if (fuse_next) begin
							grp_q <= 1'b1;
							g_q <= 3'd0;
							state_q <= S_GSTART;
						end else if (more_grp) begin
							g_q <= g_q + 3'd1;
							state_q <= S_GSTART;
						end else begin
							grp_q <= 1'b0;
							state_q <= S_IDLE;
						end
					end
				end
				S_GSTART: begin
					i_q <= {1'b0, bounds[7:0]};
					end_q <= bounds[15:8];
					any_q <= 1'b0;
					state_q <= S_GREAD;
				end
				S_GREAD: begin
					if (i_q < end_ext && i_q < 9'(NUM_ELEMENTS)) begin
						state_q <= S_GCHECK;
					end else begin
						res_q <= '0;
						res_q.result_index <= end_q;
						res_q.is_fused <= 1'b1;
						if (any_q) begin
							res_q.out_mean <= am_q;
							res_q.out_variance <= av_q;
							res_q.applied <= end_ext < 9'(NUM_ELEMENTS);
						end
						wr_en_q <= any_q && (end_ext < 9'(NUM_ELEMENTS));
						wr_addr_q <= IW'(end_q);
						state_q <= S_EMIT;
					end
				end
				S_GCHECK: begin
					if (ev == 32'd0) begin
						i_q <= i_q + 9'd1;
						state_q <= S_GREAD;
					end else if (!any_q) begin
						am_q <= em;
						av_q <= ev;
						any_q <= 1'b1;
						i_q <= i_q + 9'd1;
						state_q <= S_GREAD;
					end else begin
						cm0_q <= am_q;
						ca_q <= av_q;
						cm1_q <= em;
						cb_q <= ev;
						fusing_q <= 1'b1;
						state_q <= S_PREP;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

	// The state register always holds exactly one state.
	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("sequencer state is not one-hot");

	// The arithmetic unit only completes while the sequencer waits for it.
	a_alu_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		alu_done |-> (state_q == S_MUL1 || state_q == S_DIV1 ||
			state_q == S_MUL2 || state_q == S_DIV2))
		else $error("arithmetic result arrived outside a wait state");

	// A fused result never reports an arithmetic error.
	a_fused_no_error: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.is_fused) |-> !out_q.math_error)
		else $error("fused result flagged an error");

	// A request of the unused kind returns to idle without a result.
	a_none_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DECIDE && kind_q == K_NONE) |=> (state_q == S_IDLE))
		else $error("unused request kind did not return to idle");

endmodule
